// ===== rtl/rotary_knob_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// Rotary knob decoder assertion macros
// Clocked property checks on clk; they can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef ROTARY_KNOB_DECODER_TOP_MACROS_SVH
`define ROTARY_KNOB_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// check while out of reset
`define RKD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rotary knob decoder: property violated");

// check on every edge, reset included
`define RKD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rotary knob decoder: property violated");

`else

`define RKD_ASSERT(lbl, prop)
`define RKD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== rtl/rkd_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotary knob decoder package
// Item kinds, quadrature step table, press queue handshake types.
// ----------------------------------------------------------------------------
package rkd_pkg;

  localparam int PRESS_QUEUE_DEPTH_DEF = 8;

  localparam int POS_W   = 8;
  localparam int PRESS_W = 16;

  localparam logic [1:0] KIND_SCAN       = 2'd0;
  localparam logic [1:0] KIND_READ_MOVE  = 2'd1;
  localparam logic [1:0] KIND_POP_PRESS  = 2'd2;

  localparam logic [PRESS_W-1:0] HOLD_MAX = '1;

  // index is {last A, last B, new A, new B}
  localparam logic [POS_W-1:0] QUAD_STEP [16] = '{
    8'h00, 8'hFF, 8'h01, 8'h00,
    8'h01, 8'h00, 8'h00, 8'hFF,
    8'hFF, 8'h00, 8'h00, 8'h01,
    8'h00, 8'h01, 8'hFF, 8'h00
  };

  typedef struct packed {
    logic push;
    logic pop;
  } rkd_fifo_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } rkd_fifo_status_t;

endpackage

// ===== rtl/rkd_press_fifo.sv =====
// ----------------------------------------------------------------------------
// Press length queue
// Circular buffer of press lengths with a registered show-ahead head word.
// ----------------------------------------------------------------------------
`include "rotary_knob_decoder_top_macros.svh"

module rkd_press_fifo #(
  parameter int DEPTH = rkd_pkg::PRESS_QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rkd_pkg::rkd_fifo_req_t           req,
  input  logic [rkd_pkg::PRESS_W-1:0]      wr_data,
  output logic [rkd_pkg::PRESS_W-1:0]      rd_data,
  output rkd_pkg::rkd_fifo_status_t        status
);
  import rkd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = AW + 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [PRESS_W-1:0] mem [DEPTH];
  logic [PRESS_W-1:0] rd_data_r;
  logic [AW-1:0]      head_r, head_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [SW-1:0]      wr_sum;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;

  assign status.empty = (fill_r == '0);
  assign status.full  = (fill_r == FW'(DEPTH));
  assign wr_en        = req.push && !status.full;
  assign wr_sum       = {1'b0, head_r} + SW'(fill_r);
  assign wr_addr      = (wr_sum >= SW'(DEPTH)) ? AW'(wr_sum - SW'(DEPTH)) : AW'(wr_sum);
  assign rd_data      = rd_data_r;

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (req.pop && !status.empty) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end
    if (wr_en) begin
      fill_nxt = fill_nxt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  // forward a write that lands on the next head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= (wr_en && (wr_addr == head_nxt)) ? wr_data : mem[head_nxt];
  end

  `RKD_ASSERT(a_fill_bound, fill_r <= FW'(DEPTH))
  `RKD_ASSERT(a_pop_empty_holds, (req.pop && status.empty && !req.push) |=> $stable(fill_r))
  `RKD_ASSERT(a_push_full_holds, (req.push && status.full && !req.pop) |=> $stable(fill_r))

endmodule

// ===== rtl/rotary_knob_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Rotary knob decoder
// Quadrature knob position tracking with push button press timing.
//
//   channel  direction  handshake          beat contents
//   in       input      in_valid/in_stall  kind, pin_a, pin_b, button_level
//   out      output     out_valid/out_stall movement, press_length, press_dropped
//
// One item per cycle while out_stall is low; an input beat passes through the
// input register, then the state update into the result register.
// rst_n is synchronous; no clearing pass, the press queue is usable at once.
// in_stall rises only when the input register is full and the result
// register is held by out_stall.
// ----------------------------------------------------------------------------
`include "rotary_knob_decoder_top_macros.svh"

module rotary_knob_decoder_top #(
  parameter int PRESS_QUEUE_DEPTH = rkd_pkg::PRESS_QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_kind,
  input  logic                               in_pin_a,
  input  logic                               in_pin_b,
  input  logic                               in_button_level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rkd_pkg::POS_W-1:0]   out_movement,
  output logic [rkd_pkg::PRESS_W-1:0]        out_press_length,
  output logic                               out_press_dropped
);
  import rkd_pkg::*;

  logic               a_valid_r;
  logic [1:0]         a_kind_r;
  logic               a_pin_a_r;
  logic               a_pin_b_r;
  logic               a_button_r;

  logic [1:0]         last_pins_r, last_pins_nxt;
  logic [POS_W-1:0]   position_r, position_nxt;
  logic [PRESS_W-1:0] hold_count_r, hold_count_nxt;

  logic               out_valid_r;
  logic [POS_W-1:0]   movement_r, movement_nxt;
  logic [PRESS_W-1:0] press_length_r, press_length_nxt;
  logic               dropped_r, dropped_nxt;

  logic               advance;
  logic               fire;
  logic [3:0]         quad_idx;
  logic [PRESS_W-1:0] fifo_rd_data;
  rkd_fifo_req_t      fifo_req;
  rkd_fifo_status_t   fifo_status;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = a_valid_r && advance;
  assign in_stall = a_valid_r && !advance;
  assign quad_idx = {last_pins_r, a_pin_a_r, a_pin_b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (!in_stall) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      a_kind_r   <= in_kind;
      a_pin_a_r  <= in_pin_a;
      a_pin_b_r  <= in_pin_b;
      a_button_r <= in_button_level;
    end
  end

  always_comb begin
    last_pins_nxt    = last_pins_r;
    position_nxt     = position_r;
    hold_count_nxt   = hold_count_r;
    movement_nxt     = '0;
    press_length_nxt = '0;
    dropped_nxt      = 1'b0;
    fifo_req         = '0;
    unique case (a_kind_r)
      KIND_SCAN: begin
        position_nxt  = position_r + QUAD_STEP[quad_idx];
        last_pins_nxt = quad_idx[1:0];
        if (a_button_r) begin
          if (hold_count_r != '0) begin
            fifo_req.push  = fire;
            dropped_nxt    = fifo_status.full;
            hold_count_nxt = '0;
          end
        end else if (hold_count_r != HOLD_MAX) begin
          hold_count_nxt = hold_count_r + 1'b1;
        end
      end
      KIND_READ_MOVE: begin
        movement_nxt = position_r;
        position_nxt = '0;
      end
      KIND_POP_PRESS: begin
        fifo_req.pop = fire;
        if (!fifo_status.empty) begin
          press_length_nxt = fifo_rd_data;
        end
      end
      default: begin
      end
    endcase
  end

  rkd_press_fifo #(
    .DEPTH (PRESS_QUEUE_DEPTH)
  ) u_press_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (fifo_req),
    .wr_data (hold_count_r),
    .rd_data (fifo_rd_data),
    .status  (fifo_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pins_r  <= '0;
      position_r   <= '0;
      hold_count_r <= '0;
    end else if (fire) begin
      last_pins_r  <= last_pins_nxt;
      position_r   <= position_nxt;
      hold_count_r <= hold_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      movement_r     <= movement_nxt;
      press_length_r <= press_length_nxt;
      dropped_r      <= dropped_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_movement      = movement_r;
  assign out_press_length  = press_length_r;
  assign out_press_dropped = dropped_r;

  `RKD_ASSERT(a_stall_needs_item, in_stall |-> a_valid_r)
  `RKD_ASSERT(a_drop_only_on_scan, (fire && a_kind_r != KIND_SCAN) |=> !out_press_dropped)
  `RKD_ASSERT(a_read_clears_position, (fire && a_kind_r == KIND_READ_MOVE) |=> (position_r == '0))

endmodule
